>>> hdl/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the pattern deletion filter.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_LEN_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_terminator;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_item_t;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // classified request as it travels from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } req_t;

endpackage

>>> hdl/pdf_front.sv
// ----------------------------------------------------------------------------
// pdf_front
// Input stage: takes requests, classifies them into byte or flush ops and
// hands them to the queue.
// ----------------------------------------------------------------------------
module pdf_front import pdf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_push,
    output req_t     q_req,
    input  logic     q_ready
);

    logic stage_valid_reg;
    logic stage_valid_next;
    req_t stage_req_reg;
    req_t stage_req_next;

    assign s_ready = !stage_valid_reg || q_ready;
    assign q_push  = stage_valid_reg;
    assign q_req   = stage_req_reg;

    always_comb begin
        stage_valid_next = stage_valid_reg && !q_ready;
        stage_req_next   = stage_req_reg;
        if (s_valid && s_ready) begin
            stage_valid_next = 1'b1;
            if (s_data.is_terminator) begin
                stage_req_next.op   = OP_FLUSH;
                stage_req_next.data = 8'd0;
            end else begin
                stage_req_next.op   = OP_BYTE;
                stage_req_next.data = s_data.data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        stage_req_reg <= stage_req_next;
    end

endmodule

>>> hdl/pdf_queue.sv
// ----------------------------------------------------------------------------
// pdf_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module pdf_queue import pdf_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_req,
    output logic push_ready,
    output logic pop_valid,
    output req_t pop_req,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    req_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_req    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

>>> hdl/pdf_back.sv
// ----------------------------------------------------------------------------
// pdf_back
// Window engine: appends bytes, compares the window against the pattern,
// drops matches, emits the oldest byte otherwise, and flushes on end of
// string. One window step per cycle into a free result register.
// ----------------------------------------------------------------------------
module pdf_back import pdf_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  req_t                  q_req,
    output logic                  q_pop,
    input  logic [CFG_DATA_W-1:0] pattern_bytes,
    input  logic [PAT_LEN_W-1:0]  pattern_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int WIN_W = MAX_PATTERN * 8;
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [CNT_W-1:0]     CNT_MAX = CNT_W'(MAX_PATTERN);
    localparam logic [PAT_LEN_W-1:0] LEN_MAX = PAT_LEN_W'(MAX_PATTERN);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LOOP,
        MODE_FLUSH
    } mode_t;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;

    logic             out_free;
    logic [CNT_W-1:0] eff_len;
    logic [WIN_W-1:0] win_app;
    logic [CNT_W-1:0] cnt_app;
    logic [WIN_W-1:0] win_w;
    logic [CNT_W-1:0] cnt_w;
    logic             is_match;
    logic             do_step;
    logic             do_flush;
    logic [CNT_W-1:0] cnt_after;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // zero length counts as one, overlong clamps to the window size
    always_comb begin
        if (pattern_length == '0) begin
            eff_len = CNT_W'(1);
        end else if (pattern_length > LEN_MAX) begin
            eff_len = CNT_MAX;
        end else begin
            eff_len = CNT_W'(pattern_length);
        end
    end

    // append the incoming byte behind the pending ones
    always_comb begin
        win_app = win_reg;
        cnt_app = cnt_reg;
        if (cnt_reg < CNT_MAX) begin
            win_app[cnt_reg[IDX_W-1:0]*8 +: 8] = q_req.data;
            cnt_app = cnt_reg + 1'b1;
        end
    end

    assign win_w = (mode_reg == MODE_IDLE) ? win_app : win_reg;
    assign cnt_w = (mode_reg == MODE_IDLE) ? cnt_app : cnt_reg;

    // parallel compare of the oldest eff_len bytes
    always_comb begin
        is_match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((CNT_W'(k) < eff_len) && (win_w[k*8 +: 8] != pattern_bytes[k*8 +: 8])) begin
                is_match = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        do_step        = 1'b0;
        do_flush       = 1'b0;
        cnt_after      = cnt_w;

        if (out_free) begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (q_valid) begin
                        q_pop = 1'b1;
                        if (q_req.op == OP_FLUSH) begin
                            do_flush = 1'b1;
                        end else begin
                            do_step = 1'b1;
                        end
                    end
                end
                MODE_LOOP: begin
                    do_step = 1'b1;
                end
                MODE_FLUSH: begin
                    do_flush = 1'b1;
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        if (do_flush) begin
            out_valid_next = 1'b1;
            if (cnt_reg == '0) begin
                // empty end marker
                out_data_next.out_byte  = 8'd0;
                out_data_next.out_valid = 1'b0;
                out_data_next.out_last  = 1'b1;
                mode_next               = MODE_IDLE;
            end else begin
                out_data_next.out_byte  = win_reg[7:0];
                out_data_next.out_valid = 1'b1;
                out_data_next.out_last  = (cnt_reg == CNT_W'(1));
                win_next                = win_reg >> 8;
                cnt_next                = cnt_reg - 1'b1;
                mode_next = (cnt_reg == CNT_W'(1)) ? MODE_IDLE : MODE_FLUSH;
            end
        end

        if (do_step) begin
            win_next = win_w;
            cnt_next = cnt_w;
            if (cnt_w >= eff_len) begin
                if (is_match) begin
                    win_next  = win_w >> {eff_len, 3'b000};
                    cnt_after = cnt_w - eff_len;
                end else begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_byte  = win_w[7:0];
                    out_data_next.out_valid = 1'b1;
                    out_data_next.out_last  = 1'b0;
                    win_next                = win_w >> 8;
                    cnt_after               = cnt_w - 1'b1;
                end
                cnt_next = cnt_after;
            end
            // keep stepping while a shortened pattern still fits
            mode_next = (cnt_next >= eff_len) ? MODE_LOOP : MODE_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            cnt_reg       <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

endmodule

>>> hdl/pattern_deletion_filter.sv
// ----------------------------------------------------------------------------
// pattern_deletion_filter
// Deletes every non-overlapping occurrence of a configured byte pattern
// from a terminated byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per byte (data_byte); a request with
//     is_terminator set ends the string and flushes the pending bytes.
//   m_ channel: kept bytes in order; the final result of a string has
//     out_last set, and an empty string ends with out_valid = 0.
//   cfg channel: index 0 = pattern bytes (first byte in bits 7:0),
//     index 1 = pattern length (0 acts as 1). Always ready; write only
//     while the filter is idle. Unknown indexes are ignored.
// Path: a result shows on m_valid once the request that releases it has
//   passed the input stage register, a queue slot and the window engine
//   result register, in that order.
// Throughput: one byte per cycle while results drain. The window engine does
//   one step a cycle, so a terminator takes one step per pending byte (one if
//   none) and a byte that releases several results one step per result.
// Reset: pattern = 0, length = 1, window empty, queue empty.
// Stall: a held result stops the window engine; the queue and the input
//   stage keep taking requests until they fill, then s_ready drops.
// ----------------------------------------------------------------------------
module pattern_deletion_filter import pdf_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [CFG_DATA_W-1:0] pattern_bytes_next;
    logic [PAT_LEN_W-1:0]  pattern_length_reg;
    logic [PAT_LEN_W-1:0]  pattern_length_next;

    logic fq_push;
    req_t fq_req;
    logic fq_ready;
    logic qb_valid;
    req_t qb_req;
    logic qb_pop;

    // config registers: loaded on cfg_valid, no backpressure
    assign cfg_ready = 1'b1;

    always_comb begin
        pattern_bytes_next  = pattern_bytes_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PATTERN_BYTES: begin
                    pattern_bytes_next = cfg_data;
                end
                CFG_PATTERN_LENGTH: begin
                    pattern_length_next = cfg_data[PAT_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= PAT_LEN_W'(1);
        end else begin
            pattern_bytes_reg  <= pattern_bytes_next;
            pattern_length_reg <= pattern_length_next;
        end
    end

    // front: take and classify requests
    pdf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (fq_push),
        .q_req   (fq_req),
        .q_ready (fq_ready)
    );

    // decoupling queue
    pdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fq_push),
        .push_req   (fq_req),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_req    (qb_req),
        .pop        (qb_pop)
    );

    // back: window compare, drop, emit, flush
    pdf_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_req          (qb_req),
        .q_pop          (qb_pop),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

>>> sim/tb_pattern_deletion_filter.sv
// ----------------------------------------------------------------------------
// tb_pattern_deletion_filter
// Self-checking bench for the pattern deletion filter. A short directed run
// covers the reset pattern, zero and overlong lengths, a full eight-byte
// deletion and a length change with bytes still pending. It is followed by
// random strings built from whole patterns, partial prefixes and noise under
// a range of settings. Both handshakes stall at random. Every result is
// compared with a byte-level prediction of the filter.
// ----------------------------------------------------------------------------
module tb_pattern_deletion_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import pdf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int MAX_SPAN      = 8;
    localparam int RANDOM_ITEMS  = 175;
    localparam int SETTLE_CYCLES = 16;      // pipeline depth plus margin
    localparam int LIMIT_CYCLES  = 400000;

    // ------------------------------------------------------------------------
    // Prediction of the filter state and queue of expected kept bytes
    // ------------------------------------------------------------------------
    class kept_byte_board;
        logic [CFG_DATA_W-1:0] pattern;
        logic [PAT_LEN_W-1:0]  length_reg;
        logic [7:0]            window [MAX_SPAN];
        int                    held;
        out_item_t             kept_q [$];
        int                    mismatches;

        function new();
            pattern    = '0;
            length_reg = PAT_LEN_W'(1);
            foreach (window[k]) window[k] = 8'h00;
            held       = 0;
            mismatches = 0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_BYTES:  pattern = value;
                CFG_PATTERN_LENGTH: length_reg = value[PAT_LEN_W-1:0];
                default: ;          // unknown index, write is dropped
            endcase
        endfunction

        // length actually compared: zero acts as one, clipped to the window
        function int span();
            int s;
            s = int'(length_reg);
            if (s == 0) s = 1;
            if (s > MAX_SPAN) s = MAX_SPAN;
            return s;
        endfunction

        function void queue_result(logic [7:0] b, logic v, logic l);
            out_item_t r;
            r.out_byte  = b;
            r.out_valid = v;
            r.out_last  = l;
            kept_q.push_back(r);
        endfunction

        function void drop_front(int n);
            for (int k = 0; k < MAX_SPAN; k++) begin
                if (k + n < held) window[k] = window[k + n];
                else window[k] = 8'h00;
            end
            held -= n;
        endfunction

        function void absorb_request(in_item_t req);
            int  len;
            bit  hit;
            len = span();
            if (req.is_terminator) begin
                if (held == 0) begin
                    queue_result(8'h00, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < held; k++)
                        queue_result(window[k], 1'b1, k == held - 1);
                end
                foreach (window[k]) window[k] = 8'h00;
                held = 0;
                return;
            end
            if (held < MAX_SPAN) begin
                window[held] = req.data_byte;
                held++;
            end
            // repeats after a length cut, so one byte can release several
            while (held >= len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (window[k] != pattern[8*k +: 8]) hit = 1'b0;
                if (hit) begin
                    drop_front(len);
                end else begin
                    queue_result(window[0], 1'b1, 1'b0);
                    drop_front(1);
                end
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (kept_q.size() == 0) begin
                report($sformatf("unexpected result byte=%02h valid=%0b last=%0b",
                                 got.out_byte, got.out_valid, got.out_last));
                return;
            end
            want = kept_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
            if (got.out_valid !== want.out_valid)
                report($sformatf("out_valid %0b, expected %0b", got.out_valid, want.out_valid));
            if (got.out_last !== want.out_last)
                report($sformatf("out_last %0b, expected %0b", got.out_last, want.out_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    kept_byte_board board = new();
    bit             quiet = 1'b0;   // set for stretches with no idling on either side
    int             requests_sent = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    pattern_deletion_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Driver helpers
    // ------------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One request on the s_ channel. Valid is left high on return so that a
    // following request with no gap goes out on the very next edge; whoever
    // pauses the sender lowers it.
    task automatic push_request(input logic [7:0] b, input logic term);
        in_item_t req;
        int       gap;
        req.data_byte     = b;
        req.is_terminator = term;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.absorb_request(req);
        requests_sent++;
    endtask

    // Holds the sender until every predicted result has been seen, then lets
    // the pipeline settle: bytes that only fill the window give no result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.kept_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; only called after wait_idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        board.note_reg(idx, value);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = quiet ? 0 : gap_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] pat;
        logic [CFG_DATA_W-1:0] len_word;
        int                    len, nseg, cut, pick, phase_end;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-byte pattern of zero, so zero bytes vanish
        // while the opposite extreme passes; both terminators hit an empty
        // window and give the bare end marker.
        push_request(8'h00, 1'b0);
        push_request(8'hFF, 1'b0);
        push_request(8'h00, 1'b0);
        push_request(8'h00, 1'b1);
        push_request(8'hFF, 1'b1);

        // Length register of zero behaves as one.
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, '0);
        write_reg(CFG_PATTERN_BYTES, 64'h41);
        push_request(8'h41, 1'b0);
        push_request(8'h7E, 1'b0);
        push_request(8'h41, 1'b0);
        push_request(8'h5A, 1'b1);

        // Overlong length clips to eight; a whole-pattern string leaves
        // nothing, so the terminator gives the end marker.
        wait_idle();
        write_reg(CFG_PATTERN_BYTES, 64'h8877665544332211);
        write_reg(CFG_PATTERN_LENGTH, 64'hF);
        for (int k = 0; k < MAX_SPAN; k++) push_request(8'(8'h11 * (k + 1)), 1'b0);
        push_request(8'h00, 1'b1);

        // Cut the length with five bytes pending: the next byte drops the
        // leading pair and releases three bytes at once; flush marks the last.
        push_request(8'h11, 1'b0);
        push_request(8'h22, 1'b0);
        push_request(8'h33, 1'b0);
        push_request(8'hAA, 1'b0);
        push_request(8'hBB, 1'b0);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, 64'h2);
        push_request(8'h55, 1'b0);
        push_request(8'hC3, 1'b1);

        // Random phases: new settings, then strings made of pattern copies,
        // partial prefixes and noise. Some strings stay open across the next
        // settings change.
        phase_end = requests_sent;
        while (requests_sent < 25 + RANDOM_ITEMS) begin
            wait_idle();
            quiet = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < MAX_SPAN; k++) pat[8*k +: 8] = 8'($urandom_range(1, 255));
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                pat = '1;
            end else if (pick == 1) begin
                pat = '0;
            end else if (pick == 2) begin
                cut = $urandom_range(0, MAX_SPAN - 1);
                pat[8*cut +: 8] = 8'h00;    // literal zero inside the pattern
            end

            len_word = {$urandom, $urandom};    // upper bits must be ignored
            case ($urandom_range(0, 5))
                0:       len_word[PAT_LEN_W-1:0] = PAT_LEN_W'(0);
                1:       len_word[PAT_LEN_W-1:0] = PAT_LEN_W'(1);
                2:       len_word[PAT_LEN_W-1:0] = PAT_LEN_W'(MAX_SPAN);
                3:       len_word[PAT_LEN_W-1:0] =
                             PAT_LEN_W'($urandom_range(MAX_SPAN + 1, 15));
                default: len_word[PAT_LEN_W-1:0] =
                             PAT_LEN_W'($urandom_range(2, MAX_SPAN - 1));
            endcase
            len = int'(len_word[PAT_LEN_W-1:0]);
            if (len == 0) len = 1;
            if (len > MAX_SPAN) len = MAX_SPAN;

            if ($urandom_range(0, 1)) begin
                write_reg(CFG_PATTERN_BYTES, pat);
                write_reg(CFG_PATTERN_LENGTH, len_word);
            end else begin
                write_reg(CFG_PATTERN_LENGTH, len_word);
                write_reg(CFG_PATTERN_BYTES, pat);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_PATTERN_LENGTH + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          {$urandom, $urandom});

            phase_end = requests_sent + $urandom_range(10, 30);
            while (requests_sent < phase_end) begin
                nseg = $urandom_range(0, 5);
                for (int s = 0; s < nseg; s++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        for (int k = 0; k < len; k++) push_request(pat[8*k +: 8], 1'b0);
                    end else if (pick < 6) begin
                        // prefix that usually breaks off before a match
                        cut = $urandom_range(1, len);
                        for (int k = 0; k < cut; k++) push_request(pat[8*k +: 8], 1'b0);
                    end else if (pick < 9) begin
                        push_request(8'($urandom_range(0, 255)), 1'b0);
                    end else begin
                        push_request(pat[7:0], 1'b0);
                    end
                end
                if ($urandom_range(0, 4) != 0) push_request(8'($urandom_range(0, 255)), 1'b1);
                // sender holds off until the result side has caught up
                if ($urandom_range(0, 9) == 0) wait_idle();
            end
        end

        quiet = 1'b0;
        wait_idle();
        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
